[rtl/core/ffal_pkg.sv]
// Package for the first-fit free-list allocator: arena sizes, field widths,
// request codes and walk bounds. No dependencies.
`default_nettype none

package ffal_pkg;

    localparam int HEAP_UNITS  = 4096;
    localparam int MIN_GROW    = 1024;
    localparam int UNIT_BYTES  = 8;
    localparam int UNIT_SHIFT  = $clog2(UNIT_BYTES);

    localparam int IDX_W   = 12;
    localparam int SIZE_W  = 13;
    localparam int BYTES_W = 15;

    localparam int ALLOC_BOUND   = 3 * HEAP_UNITS + 8;
    localparam int RELEASE_BOUND = HEAP_UNITS + 2;
    localparam int ASTEP_W = $clog2(ALLOC_BOUND + 1);
    localparam int ISTEP_W = $clog2(RELEASE_BOUND + 1);

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [SIZE_W-1:0] size_t;

    typedef enum logic
    {
        REQ_ALLOC   = 1'b0,
        REQ_RELEASE = 1'b1
    } req_type_t;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_OOM = 1'b1;

endpackage : ffal_pkg

`default_nettype wire

[rtl/core/ffal_req_if.sv]
// Request channel interface of the allocator (valid/ready plus payload).
// Depends on ffal_pkg.
`default_nettype none

interface ffal_req_if
    import ffal_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 req_type;
    logic [BYTES_W-1:0]   byte_count;
    logic [IDX_W-1:0]     release_address;

    modport source (output valid, output req_type, output byte_count,
                    output release_address, input ready);
    modport sink   (input valid, input req_type, input byte_count,
                    input release_address, output ready);
endinterface : ffal_req_if

`default_nettype wire

[rtl/core/ffal_rsp_if.sv]
// Response channel interface of the allocator (valid/ready plus payload).
// Depends on ffal_pkg.
`default_nettype none

interface ffal_rsp_if
    import ffal_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             status;
    logic [IDX_W-1:0] data_address;

    modport source (output valid, output status, output data_address, input ready);
    modport sink   (input valid, input status, input data_address, output ready);
endinterface : ffal_rsp_if

`default_nettype wire

[rtl/core/first_fit_free_list_allocator_core.sv]
// Top level of the first-fit free-list allocator: sequencer, header memories
// and heap registers. Depends on ffal_pkg, ffal_req_if and ffal_rsp_if.
//
//  channel | dir | handshake        | payload
//  --------+-----+------------------+-----------------------------------------
//  req     | in  | valid/ready      | req_type, byte_count, release_address
//  rsp     | out | valid/ready      | status, data_address
//  cfg     | in  | cfg_we (no wait) | cfg_data -> heap_limit
//
//  An allocate walks the free list from the rover, one header at a time; a
//  release walks it by address to its insert point, and one outside the
//  arena is dropped. A heap grow adds an address-ordered insert walk; the very
//  first request also sets up the sentinel. The single read port of the link
//  and size memories paces these walks, and a stalled response adds its stall.
//  Reset clears the control state only; the header memories need no clearing,
//  the sentinel is written by the first request. The block takes no new
//  request until its response has been taken by the sink.
`default_nettype none

module first_fit_free_list_allocator_core
    import ffal_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    ffal_req_if.sink          req,
    ffal_rsp_if.source        rsp,
    input  wire logic         cfg_we,
    input  wire logic [12:0]  cfg_data
);

    typedef enum logic [14:0]
    {
        S_IDLE    = 15'b000000000000001,
        S_INIT    = 15'b000000000000010,
        S_DISP    = 15'b000000000000100,
        S_ASTART  = 15'b000000000001000,
        S_AP      = 15'b000000000010000,
        S_ACHK    = 15'b000000000100000,
        S_AUNL    = 15'b000000001000000,
        S_ASPLIT  = 15'b000000010000000,
        S_AGROWN  = 15'b000000100000000,
        S_ISTART  = 15'b000001000000000,
        S_IWALK   = 15'b000010000000000,
        S_ISB     = 15'b000100000000000,
        S_ISN     = 15'b001000000000000,
        S_ISP     = 15'b010000000000000,
        S_RESP    = 15'b100000000000000
    } state_t;

    // Control and heap state
    state_t               state_reg, state_next;
    logic                 list_ready_reg, list_ready_next;
    idx_t                 rover_reg, rover_next;
    size_t                heap_break_reg, heap_break_next;
    size_t                heap_limit_reg;
    logic                 ins_grow_reg, ins_grow_next;   // insert returns to allocate

    // Request and walk working registers
    logic                 req_type_reg, req_type_next;
    size_t                units_reg, units_next;
    idx_t                 addr_in_reg, addr_in_next;
    idx_t                 p_reg, p_next;
    idx_t                 prev_reg, prev_next;
    idx_t                 n_reg, n_next;
    idx_t                 bp_reg, bp_next;
    size_t                szbp_reg, szbp_next;
    idx_t                 lnkbp_reg, lnkbp_next;
    logic [ASTEP_W-1:0]   steps_reg, steps_next;
    logic [ISTEP_W-1:0]   isteps_reg, isteps_next;
    logic                 status_reg, status_next;
    idx_t                 dout_reg, dout_next;

    // Header memories: one write and one registered read each per cycle
    idx_t   link_mem [HEAP_UNITS];
    size_t  size_mem [HEAP_UNITS];
    idx_t   link_q;
    size_t  size_q;
    idx_t   lk_raddr, lk_waddr, lk_wdata;
    idx_t   sz_raddr, sz_waddr;
    size_t  sz_wdata;
    logic   lk_we, sz_we;

    always_ff @(posedge clk)
    begin
        if (lk_we)
        begin
            link_mem[lk_waddr] <= lk_wdata;
        end
        link_q <= link_mem[lk_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (sz_we)
        begin
            size_mem[sz_waddr] <= sz_wdata;
        end
        size_q <= size_mem[sz_raddr];
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_limit_reg <= size_t'(HEAP_UNITS);
        end
        else if (cfg_we)
        begin
            heap_limit_reg <= cfg_data;
        end
    end

    // Shared arithmetic terms
    logic [BYTES_W:0]  bytes_round;
    size_t             units_in;
    size_t             limit_eff;
    size_t             grow_units;
    logic [SIZE_W:0]   grow_end;
    size_t             s_rem;
    logic              ins_found;
    logic [SIZE_W:0]   bp_end;
    logic [SIZE_W:0]   p_end;

    assign bytes_round = {1'b0, req.byte_count} + (BYTES_W+1)'(UNIT_BYTES - 1);
    assign units_in    = SIZE_W'(bytes_round >> UNIT_SHIFT) + size_t'(1);
    assign limit_eff   = (heap_limit_reg > size_t'(HEAP_UNITS)) ? size_t'(HEAP_UNITS)
                                                                : heap_limit_reg;
    assign grow_units  = (units_reg < size_t'(MIN_GROW)) ? size_t'(MIN_GROW) : units_reg;
    assign grow_end    = {1'b0, heap_break_reg} + {1'b0, grow_units};
    assign s_rem       = size_q - units_reg;
    assign ins_found   = ((bp_reg > p_reg) && (bp_reg < link_q))
                      || ((p_reg >= link_q) && ((bp_reg > p_reg) || (bp_reg < link_q)));
    assign bp_end      = (SIZE_W+1)'(bp_reg) + (SIZE_W+1)'(szbp_reg);
    assign p_end       = (SIZE_W+1)'(p_reg) + (SIZE_W+1)'(size_q);

    always_comb
    begin
        state_next      = state_reg;
        list_ready_next = list_ready_reg;
        rover_next      = rover_reg;
        heap_break_next = heap_break_reg;
        ins_grow_next   = ins_grow_reg;
        req_type_next   = req_type_reg;
        units_next      = units_reg;
        addr_in_next    = addr_in_reg;
        p_next          = p_reg;
        prev_next       = prev_reg;
        n_next          = n_reg;
        bp_next         = bp_reg;
        szbp_next       = szbp_reg;
        lnkbp_next      = lnkbp_reg;
        steps_next      = steps_reg;
        isteps_next     = isteps_reg;
        status_next     = status_reg;
        dout_next       = dout_reg;
        lk_raddr        = p_reg;
        sz_raddr        = p_reg;
        lk_we           = 1'b0;
        lk_waddr        = p_reg;
        lk_wdata        = p_reg;
        sz_we           = 1'b0;
        sz_waddr        = p_reg;
        sz_wdata        = size_q;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    // Latch the request and set up the sentinel on first use
                    req_type_next = req.req_type;
                    units_next    = units_in;
                    addr_in_next  = req.release_address;
                    status_next   = STATUS_OK;
                    dout_next     = '0;
                    state_next    = list_ready_reg ? S_DISP : S_INIT;
                end
            end
            S_INIT:
            begin
                lk_we           = 1'b1;
                lk_waddr        = '0;
                lk_wdata        = '0;
                sz_we           = 1'b1;
                sz_waddr        = '0;
                sz_wdata        = '0;
                rover_next      = '0;
                list_ready_next = 1'b1;
                state_next      = S_DISP;
            end
            S_DISP:
            begin
                if (req_type_reg == REQ_ALLOC)
                begin
                    state_next = S_ASTART;
                end
                else if ((addr_in_reg >= idx_t'(2))
                      && ({1'b0, addr_in_reg - idx_t'(1)} < heap_break_reg))
                begin
                    bp_next       = addr_in_reg - idx_t'(1);
                    ins_grow_next = 1'b0;
                    state_next    = S_ISTART;
                end
                else
                begin
                    // Drop a release outside the arena
                    state_next = S_RESP;
                end
            end
            S_ASTART:
            begin
                prev_next  = rover_reg;
                lk_raddr   = rover_reg;
                steps_next = '0;
                state_next = S_AP;
            end
            S_AP:
            begin
                p_next     = link_q;
                sz_raddr   = link_q;
                state_next = S_ACHK;
            end
            S_ACHK:
            begin
                lk_raddr = p_reg;
                if (steps_reg == ASTEP_W'(ALLOC_BOUND))
                begin
                    status_next = STATUS_OOM;
                    state_next  = S_RESP;
                end
                else if (size_q >= units_reg)
                begin
                    if (size_q == units_reg)
                    begin
                        state_next = S_AUNL;
                    end
                    else
                    begin
                        // Trim the block and hand out its tail
                        sz_we      = 1'b1;
                        sz_waddr   = p_reg;
                        sz_wdata   = s_rem;
                        p_next     = p_reg + s_rem[IDX_W-1:0];
                        state_next = S_ASPLIT;
                    end
                end
                else if (p_reg == rover_reg)
                begin
                    if (grow_end > {1'b0, limit_eff})
                    begin
                        status_next = STATUS_OOM;
                        state_next  = S_RESP;
                    end
                    else
                    begin
                        sz_we           = 1'b1;
                        sz_waddr        = heap_break_reg[IDX_W-1:0];
                        sz_wdata        = grow_units;
                        bp_next         = heap_break_reg[IDX_W-1:0];
                        heap_break_next = grow_end[SIZE_W-1:0];
                        ins_grow_next   = 1'b1;
                        state_next      = S_ISTART;
                    end
                end
                else
                begin
                    prev_next  = p_reg;
                    steps_next = steps_reg + ASTEP_W'(1);
                    state_next = S_AP;
                end
            end
            S_AUNL:
            begin
                lk_we      = 1'b1;
                lk_waddr   = prev_reg;
                lk_wdata   = link_q;
                rover_next = prev_reg;
                dout_next  = p_reg + idx_t'(1);
                state_next = S_RESP;
            end
            S_ASPLIT:
            begin
                sz_we      = 1'b1;
                sz_waddr   = p_reg;
                sz_wdata   = units_reg;
                rover_next = prev_reg;
                dout_next  = p_reg + idx_t'(1);
                state_next = S_RESP;
            end
            S_AGROWN:
            begin
                // Resume the search from the rover left by the insert
                p_next     = rover_reg;
                prev_next  = rover_reg;
                lk_raddr   = rover_reg;
                steps_next = steps_reg + ASTEP_W'(1);
                state_next = S_AP;
            end
            S_ISTART:
            begin
                p_next      = rover_reg;
                lk_raddr    = rover_reg;
                isteps_next = '0;
                state_next  = S_IWALK;
            end
            S_IWALK:
            begin
                if (ins_found)
                begin
                    n_next     = link_q;
                    sz_raddr   = bp_reg;
                    state_next = S_ISB;
                end
                else if (isteps_reg == ISTEP_W'(RELEASE_BOUND))
                begin
                    state_next = ins_grow_reg ? S_AGROWN : S_RESP;
                end
                else
                begin
                    isteps_next = isteps_reg + ISTEP_W'(1);
                    p_next      = link_q;
                    lk_raddr    = link_q;
                    state_next  = S_IWALK;
                end
            end
            S_ISB:
            begin
                szbp_next  = size_q;
                sz_raddr   = n_reg;
                lk_raddr   = n_reg;
                state_next = S_ISN;
            end
            S_ISN:
            begin
                // Merge with the upper neighbor when they touch
                if (bp_end == (SIZE_W+1)'(n_reg))
                begin
                    sz_we      = 1'b1;
                    sz_waddr   = bp_reg;
                    sz_wdata   = szbp_reg + size_q;
                    lk_we      = 1'b1;
                    lk_waddr   = bp_reg;
                    lk_wdata   = link_q;
                    szbp_next  = szbp_reg + size_q;
                    lnkbp_next = link_q;
                end
                else
                begin
                    lk_we      = 1'b1;
                    lk_waddr   = bp_reg;
                    lk_wdata   = n_reg;
                    lnkbp_next = n_reg;
                end
                sz_raddr   = p_reg;
                state_next = S_ISP;
            end
            S_ISP:
            begin
                // Merge with the lower neighbor when they touch
                if (p_end == (SIZE_W+1)'(bp_reg))
                begin
                    sz_we    = 1'b1;
                    sz_waddr = p_reg;
                    sz_wdata = size_q + szbp_reg;
                    lk_we    = 1'b1;
                    lk_waddr = p_reg;
                    lk_wdata = lnkbp_reg;
                end
                else
                begin
                    lk_we    = 1'b1;
                    lk_waddr = p_reg;
                    lk_wdata = bp_reg;
                end
                rover_next = p_reg;
                state_next = ins_grow_reg ? S_AGROWN : S_RESP;
            end
            S_RESP:
            begin
                if (rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            list_ready_reg <= 1'b0;
            rover_reg      <= '0;
            heap_break_reg <= size_t'(1);
            ins_grow_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            list_ready_reg <= list_ready_next;
            rover_reg      <= rover_next;
            heap_break_reg <= heap_break_next;
            ins_grow_reg   <= ins_grow_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_type_reg <= req_type_next;
        units_reg    <= units_next;
        addr_in_reg  <= addr_in_next;
        p_reg        <= p_next;
        prev_reg     <= prev_next;
        n_reg        <= n_next;
        bp_reg       <= bp_next;
        szbp_reg     <= szbp_next;
        lnkbp_reg    <= lnkbp_next;
        steps_reg    <= steps_next;
        isteps_reg   <= isteps_next;
        status_reg   <= status_next;
        dout_reg     <= dout_next;
    end

    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = (state_reg == S_RESP);
    assign rsp.status       = status_reg;
    assign rsp.data_address = dout_reg;

    // The break pointer only moves up and never passes the arena end
    a_break_bound: assert property (@(posedge clk) disable iff (!rst_n)
        heap_break_reg <= size_t'(HEAP_UNITS))
        else $error("heap break beyond arena");

    a_break_mono: assert property (@(posedge clk) disable iff (!rst_n)
        (heap_break_reg != $past(heap_break_reg)) |-> (heap_break_reg > $past(heap_break_reg)))
        else $error("heap break moved down");

    a_ready_once: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(list_ready_reg) |-> $past(state_reg == S_INIT))
        else $error("sentinel flag set outside init");

    a_oom_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status == STATUS_OOM)) |-> (rsp.data_address == '0))
        else $error("address given with out-of-memory");

endmodule : first_fit_free_list_allocator_core

`default_nettype wire

[test/tb_first_fit_free_list_allocator_core.sv]
// Testbench for first_fit_free_list_allocator_core: random allocate/release traffic
// checked against a built-in free-list predictor held in a scoreboard class.
// Depends on ffal_pkg, ffal_req_if, ffal_rsp_if and the core RTL.
`default_nettype none

module tb_first_fit_free_list_allocator_core;
    import ffal_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 200000;
    localparam int DRAIN_PAUSE = 100;
    localparam int IDLE_PCT    = 7;

    // Scoreboard: mirrors the heap, predicts one response per accepted request
    // and compares the responses in order.
    class alloc_scoreboard;
        idx_t      next_free [HEAP_UNITS];
        size_t     unit_count[HEAP_UNITS];
        int        rover;
        int        brk;
        bit        list_up;
        int        limit_reg;
        bit        want_status[$];
        idx_t      want_addr[$];
        int        live[$];
        int        errors;
        int        n_grant, n_oom, n_free;

        function new();
            rover = 0;
            brk = 1;
            list_up = 0;
            limit_reg = 4096;
            errors = 0;
            n_grant = 0;
            n_oom = 0;
            n_free = 0;
        endfunction

        function void set_limit(int v);
            limit_reg = v;
        endfunction

        function void setup_sentinel();
            if (!list_up)
            begin
                next_free[0] = '0;
                unit_count[0] = '0;
                rover = 0;
                list_up = 1;
            end
        endfunction

        // Insert a block by address, merge with both neighbors.
        function void insert_free(int bp);
            int p;
            int n;
            int steps;
            p = rover;
            steps = 0;
            forever
            begin
                n = next_free[p];
                if (bp > p && bp < n)
                    break;
                if (p >= n && (bp > p || bp < n))
                    break;
                steps++;
                if (steps > RELEASE_BOUND)
                    return;
                p = n;
            end
            n = next_free[p];
            if (bp + unit_count[bp] == n)
            begin
                unit_count[bp] = unit_count[bp] + unit_count[n];
                next_free[bp] = next_free[n];
            end
            else
                next_free[bp] = n;
            if (p + unit_count[p] == bp)
            begin
                unit_count[p] = unit_count[p] + unit_count[bp];
                next_free[p] = next_free[bp];
            end
            else
                next_free[p] = bp;
            rover = p;
        endfunction

        function bit grow_heap(int units);
            int lim;
            int nu;
            int hdr;
            lim = (limit_reg > HEAP_UNITS) ? HEAP_UNITS : limit_reg;
            nu = (units < MIN_GROW) ? MIN_GROW : units;
            if (brk + nu > lim)
                return 0;
            hdr = brk;
            unit_count[hdr % HEAP_UNITS] = nu;
            brk += nu;
            insert_free(hdr % HEAP_UNITS);
            return 1;
        endfunction

        // Returns the granted data index, or -1 when out of memory.
        function int take_block(int bytes);
            int units;
            int prev;
            int p;
            int s;
            units = (bytes + UNIT_BYTES - 1) / UNIT_BYTES + 1;
            setup_sentinel();
            prev = rover;
            p = next_free[prev];
            for (int steps = 0; steps < ALLOC_BOUND; steps++)
            begin
                s = unit_count[p];
                if (s >= units)
                begin
                    if (s == units)
                        next_free[prev] = next_free[p];
                    else
                    begin
                        s -= units;
                        unit_count[p] = s;
                        p = (p + s) % HEAP_UNITS;
                        unit_count[p] = units;
                    end
                    rover = prev;
                    return (p + 1) % HEAP_UNITS;
                end
                if (p == rover)
                begin
                    if (!grow_heap(units))
                        return -1;
                    p = rover;
                end
                prev = p;
                p = next_free[p];
            end
            return -1;
        endfunction

        function void note(req_type_t kind, logic [BYTES_W-1:0] bytes, idx_t addr);
            int got;
            if (kind == REQ_ALLOC)
            begin
                got = take_block(int'(bytes));
                if (got < 0)
                begin
                    want_status.push_back(STATUS_OOM);
                    want_addr.push_back('0);
                    n_oom++;
                end
                else
                begin
                    want_status.push_back(STATUS_OK);
                    want_addr.push_back(idx_t'(got));
                    if (got != 0)
                        live.push_back(got);
                    n_grant++;
                end
            end
            else
            begin
                setup_sentinel();
                if (addr >= 2 && int'(addr) - 1 < brk)
                    insert_free(int'(addr) - 1);
                want_status.push_back(STATUS_OK);
                want_addr.push_back('0);
                n_free++;
            end
        endfunction

        function void check(logic st, idx_t addr);
            logic e_st;
            idx_t e_addr;
            if (want_status.size() == 0)
            begin
                $display("%0t: response with nothing pending: status %0d addr %0d",
                         $time, st, addr);
                errors++;
                return;
            end
            e_st = want_status.pop_front();
            e_addr = want_addr.pop_front();
            if (st !== e_st)
            begin
                $display("%0t: status mismatch: expected %0d actual %0d", $time, e_st, st);
                errors++;
            end
            if (addr !== e_addr)
            begin
                $display("%0t: data_address mismatch: expected %0d actual %0d",
                         $time, e_addr, addr);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [12:0] cfg_data;

    ffal_req_if req_ch();
    ffal_rsp_if rsp_ch();

    first_fit_free_list_allocator_core dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_ch),
        .rsp      (rsp_ch),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    alloc_scoreboard sb;
    bit calm;          // no idling on either side while set
    bit hold_request;  // ask the response side for one long hold
    int hold_left;
    int quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Drive every input to a known value from time zero.
    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_ALLOC;
        req_ch.byte_count = '0;
        req_ch.release_address = '0;
        rsp_ch.ready = 1'b0;
        calm = 1'b0;
        hold_request = 1'b0;
        hold_left = 0;
        quiet_cycles = 0;
    end

    // Response side: random stalls, plus one long hold on request so the
    // request side backs up while the sender keeps offering.
    always @(posedge clk)
    begin
        if (hold_left == 0 && hold_request)
        begin
            hold_left = 400;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // Check every accepted response against the oldest prediction.
    always @(posedge clk)
    begin
        if (rsp_ch.valid && rsp_ch.ready)
            sb.check(rsp_ch.status, rsp_ch.data_address);
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles > STALL_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Offer one request and hold it until accepted; note it on acceptance.
    task automatic send_request(req_type_t kind, logic [BYTES_W-1:0] bytes, idx_t addr);
        if (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.byte_count <= bytes;
        req_ch.release_address <= addr;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sb.note(kind, bytes, addr);
    endtask

    // Stop offering, wait for every pending response, then let the core settle.
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (sb.want_status.size() != 0)
            @(posedge clk);
        repeat (DRAIN_PAUSE) @(posedge clk);
    endtask

    task automatic write_limit(int v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= 13'(v);
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_limit(v);
    endtask

    // Release a random live block.
    task automatic free_live();
        int k;
        idx_t a;
        k = $urandom_range(sb.live.size() - 1);
        a = idx_t'(sb.live[k]);
        sb.live.delete(k);
        send_request(REQ_RELEASE, BYTES_W'($urandom), a);
    endtask

    // One random request: mostly well-formed alloc/release mixes, a few
    // releases that fall outside the arena.
    task automatic random_request();
        int pick;
        int lo;
        logic [BYTES_W-1:0] bytes;
        pick = $urandom_range(99);
        if (pick < 4)
        begin
            lo = sb.brk + 1;
            if (lo <= 4095 && $urandom_range(1))
                send_request(REQ_RELEASE, BYTES_W'($urandom),
                             idx_t'($urandom_range(4095, lo)));
            else
                send_request(REQ_RELEASE, BYTES_W'($urandom), idx_t'($urandom_range(1)));
        end
        else if (sb.live.size() != 0 && (sb.live.size() > 30 || pick < 50))
            free_live();
        else
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                bytes = BYTES_W'($urandom_range(127));
            else if (pick < 90)
                bytes = BYTES_W'($urandom_range(4095, 128));
            else
                bytes = BYTES_W'($urandom_range(32767));
            send_request(REQ_ALLOC, bytes, idx_t'($urandom));
        end
    endtask

    task automatic random_phase(int n);
        repeat (n) random_request();
    endtask

    initial
    begin
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: first request is a release (sets up the sentinel and is
        // ignored), size extremes, exact fits, merges, out-of-arena releases.
        calm = 1'b1;
        write_limit(4096);
        send_request(REQ_RELEASE, 15'h7fff, 12'hfff);
        send_request(REQ_ALLOC, 15'd0, 12'h000);
        send_request(REQ_ALLOC, 15'h7fff, 12'h000);
        send_request(REQ_ALLOC, 15'd1, 12'h000);
        send_request(REQ_ALLOC, 15'd8, 12'h000);
        send_request(REQ_ALLOC, 15'd9, 12'h000);
        send_request(REQ_ALLOC, 15'd8184, 12'h000);
        send_request(REQ_RELEASE, 15'd0, 12'd0);
        send_request(REQ_RELEASE, 15'd0, 12'd1);
        send_request(REQ_RELEASE, 15'd0, 12'd4095);
        repeat (4) free_live();
        send_request(REQ_ALLOC, 15'd16, 12'h000);
        send_request(REQ_ALLOC, 15'd16, 12'h000);
        free_live();
        send_request(REQ_ALLOC, 15'd16, 12'h000);
        send_request(REQ_ALLOC, 15'd32760, 12'h000);
        drain();

        // Long stretch with no idling, then random idling.
        random_phase(100);
        calm = 1'b0;
        random_phase(200);
        drain();

        // Smallest limit: no more growth, only the existing free list serves.
        write_limit(2);
        random_phase(80);
        drain();

        write_limit(3000);
        random_phase(250);
        drain();

        // Full limit again; stall the response side while requests keep coming.
        write_limit(4096);
        random_phase(20);
        hold_request = 1'b1;
        random_phase(200);
        drain();

        $display("covered %0d grants, %0d out-of-memory replies, %0d releases",
                 sb.n_grant, sb.n_oom, sb.n_free);
        $display("limits 4096, 2, 3000 and 4096 again; final break at unit %0d", sb.brk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule : tb_first_fit_free_list_allocator_core

`default_nettype wire
